### src/upn_pkg.sv
// Shared types, character constants and helper functions of the URL percent normalizer.
// No dependencies; every other file of the block but upn_fifo imports this package.
package upn_pkg;

	// Character and mask constants
	localparam logic [7:0] CH_PCT  = 8'h25;
	localparam logic [7:0] CH_DEL  = 8'h7F;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] HI_MASK = 8'hF0;
	localparam logic [7:0] LO_MASK = 8'h0F;

	// Record slot layout: decoded bytes, segment flush, passed mark, terminator
	localparam int N_SLOTS    = 8;
	localparam int N_DEC      = 5;
	localparam int SLOT_FLUSH = 5;
	localparam int SLOT_PASS  = 6;
	localparam int SLOT_TERM  = 7;
	localparam int N_UNITS    = 3;

	// Default queue depths
	localparam int TOK_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 2;

	// Work record of one input byte, written by the front
	typedef struct packed {
		logic [N_SLOTS-1:0]      vld;
		logic [N_SLOTS-1:0][7:0] byt;
	} upn_rec_t;

	// Output unit: a byte, sent as-is or through the escape rule
	typedef struct packed {
		logic [7:0] byt;
		logic       esc;
		logic       last;
	} upn_unit_t;

	// Group of units produced by one record slot
	typedef struct packed {
		logic [1:0]                n;
		upn_unit_t [N_UNITS-1:0]   u;
	} upn_grp_t;

	// Result item
	typedef struct packed {
		logic [7:0] byt;
		logic       last;
	} upn_out_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
			((c >= 8'h61) && (c <= 8'h66));
	endfunction

	// Value of a hex digit, either case
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if (is_digit(c)) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	// Upper-case hex digit of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = 8'h30 + {4'h0, v};
		end else begin
			c = 8'h37 + {4'h0, v};
		end
		return c;
	endfunction

	// Mark and reserved characters that split segments
	function automatic logic is_mark(input logic [7:0] c);
		logic m;
		unique case (c)
			8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h3B,
			8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2C: begin
				m = 1'b1;
			end
			default: begin
				m = 1'b0;
			end
		endcase
		return m;
	endfunction

	// Bytes that pass the escape rule unchanged
	function automatic logic is_plain(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A)) || (c >= CH_DEL);
	endfunction

endpackage

### src/upn_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Generic; no package dependency.
module upn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             push,
	output logic             full,
	output logic [WIDTH-1:0] rd_data,
	input  logic             pop,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             wr;
	logic             rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr      = push && !full;
	assign rd      = pop && !empty;
	assign rd_data = mem_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/upn_front.sv
// Front: classifies each input byte, percent-decodes its segment and writes its work record
// when any slot is valid. Depends on upn_pkg.
module upn_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              push,
	output logic              full,
	output upn_pkg::upn_rec_t rec,
	output logic              rec_push,
	input  logic              rec_full
);
	import upn_pkg::*;

	logic [1:0]            rc_q;
	logic [7:0]            h1_q;
	logic                  cut_q;
	logic                  acc;
	logic                  mark;
	logic                  end_seg;
	logic [1:0]            rc_a;
	logic [7:0]            h1_a;
	logic [N_DEC-1:0]      cand_v;
	logic [N_DEC-1:0][7:0] cand_b;
	logic                  cut;

	assign full     = rec_full;
	assign acc      = push && !rec_full;
	assign rec_push = acc && (rec.vld != '0);

	// Decode: raw hold update and candidate decoded bytes
	always_comb begin
		mark    = is_mark(in_byte);
		end_seg = mark || in_last;
		rc_a    = rc_q;
		h1_a    = h1_q;
		cand_v  = '0;
		cand_b  = '0;
		if (!mark) begin
			unique case (rc_q)
				2'd0: begin
					if (in_byte == CH_PCT) begin
						rc_a = 2'd1;
					end else begin
						cand_v[0] = 1'b1;
						cand_b[0] = in_byte;
					end
				end
				2'd1: begin
					h1_a = in_byte;
					rc_a = 2'd2;
				end
				default: begin
					if (is_hex(h1_q) && is_hex(in_byte)) begin
						cand_v[0] = 1'b1;
						cand_b[0] = {hex_val(h1_q), hex_val(in_byte)};
						rc_a      = 2'd0;
					end else begin
						// invalid escape: literal '%', rescan the held byte and this one
						cand_v[0] = 1'b1;
						cand_b[0] = CH_PCT;
						if (h1_q == CH_PCT) begin
							rc_a = 2'd2;
							h1_a = in_byte;
						end else begin
							cand_v[1] = 1'b1;
							cand_b[1] = h1_q;
							if (in_byte == CH_PCT) begin
								rc_a = 2'd1;
							end else begin
								cand_v[2] = 1'b1;
								cand_b[2] = in_byte;
								rc_a      = 2'd0;
							end
						end
					end
				end
			endcase
		end
		// short escape at segment end is kept literally
		if (end_seg) begin
			if (rc_a != 2'd0) begin
				cand_v[3] = 1'b1;
				cand_b[3] = CH_PCT;
			end
			if (rc_a == 2'd2) begin
				cand_v[4] = 1'b1;
				cand_b[4] = h1_a;
			end
		end
	end

	// Record build with segment cut after a decoded zero
	always_comb begin
		cut     = cut_q;
		rec.vld = '0;
		rec.byt = '0;
		for (int i = 0; i < N_DEC; i++) begin
			rec.byt[i] = cand_b[i];
			if (cand_v[i] && !cut) begin
				rec.vld[i] = 1'b1;
				if (cand_b[i] == CH_NUL) begin
					cut = 1'b1;
				end
			end
		end
		rec.vld[SLOT_FLUSH] = end_seg;
		rec.byt[SLOT_FLUSH] = CH_NUL;
		rec.vld[SLOT_PASS]  = mark;
		rec.byt[SLOT_PASS]  = in_byte;
		rec.vld[SLOT_TERM]  = in_last;
		rec.byt[SLOT_TERM]  = CH_NUL;
	end

	// Decoder state; a segment end empties the raw hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q  <= 2'd0;
			h1_q  <= '0;
			cut_q <= 1'b0;
		end else if (acc) begin
			if (in_last) begin
				rc_q  <= 2'd0;
				cut_q <= 1'b0;
			end else begin
				rc_q  <= end_seg ? 2'd0 : rc_a;
				h1_q  <= h1_a;
				cut_q <= end_seg ? 1'b0 : cut;
			end
		end
	end

endmodule

### src/upn_escape.sv
// Back, first part: walks the slots of each work record and runs the re-escape lookahead.
// Depends on upn_pkg; produces unit groups for upn_emit.
module upn_escape (
	input  logic              clk,
	input  logic              arst_n,
	input  upn_pkg::upn_rec_t rec,
	input  logic              rec_empty,
	output logic              rec_pop,
	output upn_pkg::upn_grp_t grp,
	output logic              grp_push,
	input  logic              grp_ready
);
	import upn_pkg::*;

	localparam int SW = $clog2(N_SLOTS);

	logic [N_SLOTS-1:0] done_q;
	logic [1:0]         cnt_q;
	logic [7:0]         h1_q;
	logic [N_SLOTS-1:0] pend;
	logic [N_SLOTS-1:0] sel_oh;
	logic [SW-1:0]      sel;
	logic               any;
	logic               last_one;
	logic               fire;
	logic [7:0]         d;
	logic [1:0]         cnt_n;
	logic [7:0]         h1_n;

	// Lowest pending slot of the head record
	always_comb begin
		pend = rec_empty ? '0 : (rec.vld & ~done_q);
		sel  = '0;
		for (int i = N_SLOTS - 1; i >= 0; i--) begin
			if (pend[i]) begin
				sel = SW'(i);
			end
		end
		sel_oh      = '0;
		sel_oh[sel] = 1'b1;
		any         = (pend != '0);
		last_one    = ((pend & ~sel_oh) == '0);
		d           = rec.byt[sel];
	end

	// Escape lookahead on the selected slot
	always_comb begin
		grp   = '0;
		cnt_n = cnt_q;
		h1_n  = h1_q;
		if (sel == SW'(SLOT_TERM)) begin
			grp.n      = 2'd1;
			grp.u[0]   = '{byt: CH_NUL, esc: 1'b0, last: 1'b1};
		end else if (sel == SW'(SLOT_PASS)) begin
			grp.n      = 2'd1;
			grp.u[0]   = '{byt: d, esc: 1'b0, last: 1'b0};
		end else if (d == CH_NUL) begin
			// flush held escape bytes
			grp.n    = cnt_q;
			grp.u[0] = '{byt: CH_PCT, esc: 1'b1, last: 1'b0};
			grp.u[1] = '{byt: h1_q, esc: 1'b1, last: 1'b0};
			cnt_n    = 2'd0;
		end else begin
			unique case (cnt_q)
				2'd0: begin
					if (d == CH_PCT) begin
						cnt_n = 2'd1;
					end else begin
						grp.n    = 2'd1;
						grp.u[0] = '{byt: d, esc: 1'b1, last: 1'b0};
					end
				end
				2'd1: begin
					h1_n  = d;
					cnt_n = 2'd2;
				end
				default: begin
					// a valid "%hh" keeps its '%', otherwise it becomes "%25"
					grp.u[0] = '{byt: CH_PCT, esc: !(is_hex(h1_q) && is_hex(d)), last: 1'b0};
					if (h1_q == CH_PCT) begin
						grp.n = 2'd1;
						h1_n  = d;
						cnt_n = 2'd2;
					end else begin
						grp.u[1] = '{byt: h1_q, esc: 1'b1, last: 1'b0};
						if (d == CH_PCT) begin
							grp.n = 2'd2;
							cnt_n = 2'd1;
						end else begin
							grp.n    = 2'd3;
							grp.u[2] = '{byt: d, esc: 1'b1, last: 1'b0};
							cnt_n    = 2'd0;
						end
					end
				end
			endcase
		end
	end

	assign fire     = any && ((grp.n == 2'd0) || grp_ready);
	assign grp_push = fire && (grp.n != 2'd0);
	assign rec_pop  = fire && last_one;

	// Slot progress and escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			cnt_q  <= 2'd0;
			h1_q   <= '0;
		end else if (fire) begin
			done_q <= last_one ? '0 : (done_q | sel_oh);
			cnt_q  <= cnt_n;
			h1_q   <= h1_n;
		end
	end

endmodule

### src/upn_emit.sv
// Back, second part: expands unit groups into result bytes, one byte per cycle
// while the result queue has room. Depends on upn_pkg; feeds the result queue.
module upn_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  upn_pkg::upn_grp_t grp,
	input  logic              grp_push,
	output logic              grp_ready,
	output upn_pkg::upn_out_t obyte,
	output logic              o_push,
	input  logic              o_full
);
	import upn_pkg::*;

	logic       busy_q;
	upn_grp_t   grp_q;
	logic [1:0] ui_q;
	logic [1:0] ph_q;
	upn_unit_t  u;
	logic       expand;
	logic       step;
	logic       unit_end;
	logic       grp_end;
	logic [7:0] hi_bits;
	logic [7:0] lo_bits;

	// Current output byte
	always_comb begin
		u       = grp_q.u[ui_q];
		expand  = u.esc && !is_plain(u.byt);
		hi_bits = u.byt & HI_MASK;
		lo_bits = u.byt & LO_MASK;
		obyte.last = u.last;
		if (!expand) begin
			obyte.byt = u.byt;
		end else begin
			unique case (ph_q)
				2'd0:    obyte.byt = CH_PCT;
				2'd1:    obyte.byt = hex_char(hi_bits[7:4]);
				default: obyte.byt = hex_char(lo_bits[3:0]);
			endcase
		end
	end

	assign step      = busy_q && !o_full;
	assign unit_end  = !expand || (ph_q == 2'd2);
	assign grp_end   = unit_end && (ui_q == (grp_q.n - 2'd1));
	assign grp_ready = !busy_q || (step && grp_end);
	assign o_push    = step;

	// Group register and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
			ui_q   <= 2'd0;
			ph_q   <= 2'd0;
		end else if (grp_push) begin
			busy_q <= 1'b1;
			grp_q  <= grp;
			ui_q   <= 2'd0;
			ph_q   <= 2'd0;
		end else if (step) begin
			if (grp_end) begin
				busy_q <= 1'b0;
			end else if (unit_end) begin
				ui_q <= ui_q + 2'd1;
				ph_q <= 2'd0;
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

endmodule

### src/url_percent_normalizer.sv
// Top level of the URL percent normalizer: front decoder, record queue, escaper, emitter, result queue.
// Depends on upn_pkg, upn_fifo, upn_front, upn_escape and upn_emit.
//
// Bytes of a URL go in one per transfer and come out normalized: mark and reserved characters
// pass and split segments, each segment is percent-decoded and re-escaped with upper-case hex,
// and the byte marked last is followed by a zero terminator with out_last set. The front takes
// one input per cycle into a record queue of TOK_DEPTH entries while that queue is not full, so
// it can accept new bytes while the back still works on earlier records. The back walks the
// decoded bytes, flush, mark and terminator of each record in order, and the emitter writes one
// result byte per cycle into a result queue of OUT_DEPTH entries while that queue has room.
module url_percent_normalizer #(
	parameter int TOK_DEPTH = upn_pkg::TOK_DEPTH_DEF,
	parameter int OUT_DEPTH = upn_pkg::OUT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       push,
	output logic       full,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       empty,
	input  logic       pop
);
	import upn_pkg::*;

	upn_rec_t                 rec_w;
	logic                     rec_push;
	logic                     rec_full;
	logic [$bits(upn_rec_t)-1:0] rec_rd;
	upn_rec_t                 rec_head;
	logic                     rec_pop;
	logic                     rec_empty;
	upn_grp_t                 grp;
	logic                     grp_push;
	logic                     grp_ready;
	upn_out_t                 obyte;
	logic                     o_push;
	logic                     o_full;
	logic [$bits(upn_out_t)-1:0] out_rd;
	upn_out_t                 out_head;

	// Front: decode and classify
	upn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.push     (push),
		.full     (full),
		.rec      (rec_w),
		.rec_push (rec_push),
		.rec_full (rec_full)
	);

	// Record queue between front and back
	upn_fifo #(
		.WIDTH ($bits(upn_rec_t)),
		.DEPTH (TOK_DEPTH)
	) u_rec_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (rec_w),
		.push    (rec_push),
		.full    (rec_full),
		.rd_data (rec_rd),
		.pop     (rec_pop),
		.empty   (rec_empty)
	);

	assign rec_head = upn_rec_t'(rec_rd);

	// Back: re-escape lookahead
	upn_escape u_escape (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec_head),
		.rec_empty (rec_empty),
		.rec_pop   (rec_pop),
		.grp       (grp),
		.grp_push  (grp_push),
		.grp_ready (grp_ready)
	);

	// Back: byte expansion
	upn_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.grp_push  (grp_push),
		.grp_ready (grp_ready),
		.obyte     (obyte),
		.o_push    (o_push),
		.o_full    (o_full)
	);

	// Result queue
	upn_fifo #(
		.WIDTH ($bits(upn_out_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (obyte),
		.push    (o_push),
		.full    (o_full),
		.rd_data (out_rd),
		.pop     (pop),
		.empty   (empty)
	);

	assign out_head = upn_out_t'(out_rd);
	assign out_byte = out_head.byt;
	assign out_last = out_head.last;

endmodule
